### design/price_level_book_defines.svh
// Assertion macros for the price level book.
`ifndef PRICE_LEVEL_BOOK_DEFINES_SVH
`define PRICE_LEVEL_BOOK_DEFINES_SVH
`ifndef SYNTH
`define PLB_ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define PLB_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define PLB_ASSERT_IMPL(label, clk, rst_n, prop)
`define PLB_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

### design/plb_pkg.sv
// ----------------------------------------------------------------------------
// plb_pkg
// Shared types and codes for the price level book.
// ----------------------------------------------------------------------------
package plb_pkg;

    localparam logic [2:0] OP_SET_BID    = 3'd0;
    localparam logic [2:0] OP_SET_ASK    = 3'd1;
    localparam logic [2:0] OP_REMOVE_BID = 3'd2;
    localparam logic [2:0] OP_REMOVE_ASK = 3'd3;
    localparam logic [2:0] OP_CLEAR      = 3'd4;
    localparam logic [2:0] OP_QUERY      = 3'd5;
    localparam logic [2:0] OP_LOAD_BID   = 3'd6;
    localparam logic [2:0] OP_LOAD_ASK   = 3'd7;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_CROSS  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    localparam int DEPTH_BITS = 38;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN1,
        S_APPLY,
        S_SCAN2,
        S_OUT
    } state_t;

endpackage

### design/plb_side.sv
// ----------------------------------------------------------------------------
// plb_side
// One side of the book: price and size memories plus used bits. Scans one
// slot a cycle through a registered read port and accumulates best price,
// match, first free slot and depth.
// ----------------------------------------------------------------------------
module plb_side #(
    parameter int LEVELS     = 64,
    parameter int PRICE_BITS = 32,
    parameter int SIZE_BITS  = 32,
    parameter bit HIGH_BEST  = 1'b1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          scan_start,
    input  logic                          scan_rd,
    input  logic [$clog2(LEVELS)-1:0]     rd_addr,
    input  logic                          scan_acc,
    input  logic [PRICE_BITS-1:0]         key,
    input  logic                          clear_all,
    input  logic                          wr_en,
    input  logic                          wr_new,
    input  logic                          drop_en,
    input  logic [$clog2(LEVELS)-1:0]     wr_addr,
    input  logic [SIZE_BITS-1:0]          wr_size,
    output logic                          any,
    output logic [PRICE_BITS-1:0]         best,
    output logic                          hit,
    output logic [$clog2(LEVELS)-1:0]     hit_idx,
    output logic                          free_ok,
    output logic [$clog2(LEVELS)-1:0]     free_idx,
    output logic [SIZE_BITS-1:0]          size_at,
    output logic [plb_pkg::DEPTH_BITS-1:0] depth
);
    import plb_pkg::*;
    localparam int AW = $clog2(LEVELS);

    logic [PRICE_BITS-1:0] price_mem [LEVELS];
    logic [SIZE_BITS-1:0]  size_mem  [LEVELS];
    logic [LEVELS-1:0]     used_reg;

    logic [PRICE_BITS-1:0] rd_price_reg;
    logic [SIZE_BITS-1:0]  rd_size_reg;
    logic                  rd_used_reg;
    logic [AW-1:0]         rd_idx_reg;

    logic                  any_reg;
    logic [PRICE_BITS-1:0] best_reg;
    logic                  hit_reg;
    logic [AW-1:0]         hit_idx_reg;
    logic                  free_reg;
    logic [AW-1:0]         free_idx_reg;
    logic [SIZE_BITS-1:0]  size_reg;
    logic [DEPTH_BITS:0]   depth_reg;
    logic                  better;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            size_mem[wr_addr] <= wr_size;
            if (wr_new)
            begin
                price_mem[wr_addr] <= key;
            end
        end
        if (scan_rd)
        begin
            rd_price_reg <= price_mem[rd_addr];
            rd_size_reg  <= size_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg    <= '0;
            rd_used_reg <= 1'b0;
            rd_idx_reg  <= '0;
        end
        else
        begin
            if (clear_all)
            begin
                used_reg <= '0;
            end
            else if (wr_en && wr_new)
            begin
                used_reg[wr_addr] <= 1'b1;
            end
            else if (drop_en)
            begin
                used_reg[wr_addr] <= 1'b0;
            end
            if (scan_rd)
            begin
                rd_used_reg <= used_reg[rd_addr];
                rd_idx_reg  <= rd_addr;
            end
        end
    end

    always_comb
    begin
        if (HIGH_BEST)
        begin
            better = rd_price_reg > best_reg;
        end
        else
        begin
            better = rd_price_reg < best_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_start)
        begin
            any_reg   <= 1'b0;
            best_reg  <= '0;
            hit_reg   <= 1'b0;
            free_reg  <= 1'b0;
            size_reg  <= '0;
            depth_reg <= '0;
        end
        else if (scan_acc)
        begin
            if (rd_used_reg)
            begin
                any_reg <= 1'b1;
                if (!any_reg || better)
                begin
                    best_reg <= rd_price_reg;
                end
                if (rd_price_reg == key)
                begin
                    hit_reg     <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                    size_reg    <= rd_size_reg;
                end
                if ((HIGH_BEST ? (rd_price_reg > key) : (rd_price_reg < key)) &&
                    !depth_reg[DEPTH_BITS])
                begin
                    depth_reg <= depth_reg + (DEPTH_BITS+1)'(rd_size_reg);
                end
            end
            else if (!free_reg)
            begin
                free_reg     <= 1'b1;
                free_idx_reg <= rd_idx_reg;
            end
        end
    end

    assign any      = any_reg;
    assign best     = best_reg;
    assign hit      = hit_reg;
    assign hit_idx  = hit_idx_reg;
    assign free_ok  = free_reg;
    assign free_idx = free_idx_reg;
    assign size_at  = size_reg;
    assign depth    = depth_reg[DEPTH_BITS] ? '1 : depth_reg[DEPTH_BITS-1:0];

endmodule

### design/price_level_book.sv
// ----------------------------------------------------------------------------
// price_level_book
// Two-sided price-level book with set, remove, clear, query and load.
// ----------------------------------------------------------------------------
// A request is accepted only while the block is idle, and its result is
// presented once two scans and an update are done: one scan of both sides'
// memories (one slot a cycle through a registered read port) finds the
// match, free slot and best prices, the apply state performs the update,
// and a second scan reports best prices, sizes and depths on the new book.
// The result is held in output registers until taken; the next request
// can be accepted in the cycle after it is taken, so a new request is never
// accepted while the last result is still waiting.
module price_level_book #(
    parameter int LEVELS     = 64,
    parameter int PRICE_BITS = 32,
    parameter int SIZE_BITS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [31:0] price,
    input  logic [31:0] size,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] best_bid,
    output logic [31:0] best_ask,
    output logic signed [32:0] spread,
    output logic [32:0] mid_doubled,
    output logic [31:0] bid_size_at,
    output logic [31:0] ask_size_at,
    output logic [37:0] bid_depth_above,
    output logic [37:0] ask_depth_below
);
    import plb_pkg::*;
    `include "price_level_book_defines.svh"
    localparam int AW = $clog2(LEVELS);
    localparam int CW = AW + 1;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [2:0]    op_reg;
    logic [PRICE_BITS-1:0] price_reg;
    logic [SIZE_BITS-1:0]  size_reg;
    logic [1:0]    status_reg, status_next;
    logic          out_valid_reg;

    logic scan_start, scan_rd, scan_acc, clear_all;
    logic bwr, bnew, bdrop, awr, anew, adrop;
    logic [AW-1:0] bwa, awa, rd_addr;

    logic b_any, a_any, b_hit, a_hit, b_free, a_free;
    logic [PRICE_BITS-1:0] b_best, a_best;
    logic [AW-1:0] b_hidx, a_hidx, b_fidx, a_fidx;
    logic [SIZE_BITS-1:0] b_sz, a_sz;
    logic [DEPTH_BITS-1:0] b_dep, a_dep;

    logic [31:0] bb32, ba32;
    logic accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign rd_addr  = cnt_reg[AW-1:0];

    plb_side #(.LEVELS(LEVELS), .PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS),
               .HIGH_BEST(1'b1)) u_bid (
        .clk(clk), .rst_n(rst_n), .scan_start(scan_start), .scan_rd(scan_rd),
        .rd_addr(rd_addr), .scan_acc(scan_acc), .key(price_reg),
        .clear_all(clear_all), .wr_en(bwr), .wr_new(bnew), .drop_en(bdrop),
        .wr_addr(bwa), .wr_size(size_reg), .any(b_any), .best(b_best),
        .hit(b_hit), .hit_idx(b_hidx), .free_ok(b_free), .free_idx(b_fidx),
        .size_at(b_sz), .depth(b_dep)
    );

    plb_side #(.LEVELS(LEVELS), .PRICE_BITS(PRICE_BITS), .SIZE_BITS(SIZE_BITS),
               .HIGH_BEST(1'b0)) u_ask (
        .clk(clk), .rst_n(rst_n), .scan_start(scan_start), .scan_rd(scan_rd),
        .rd_addr(rd_addr), .scan_acc(scan_acc), .key(price_reg),
        .clear_all(clear_all), .wr_en(awr), .wr_new(anew), .drop_en(adrop),
        .wr_addr(awa), .wr_size(size_reg), .any(a_any), .best(a_best),
        .hit(a_hit), .hit_idx(a_hidx), .free_ok(a_free), .free_idx(a_fidx),
        .size_at(a_sz), .depth(a_dep)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            price_reg <= PRICE_BITS'(price);
            size_reg  <= SIZE_BITS'(size);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            status_reg    <= ST_DONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            status_reg <= status_next;
            if (state_reg == S_SCAN2 && state_next == S_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        status_next = status_reg;
        scan_start  = 1'b0;
        scan_rd     = 1'b0;
        scan_acc    = 1'b0;
        clear_all   = 1'b0;
        bwr = 1'b0; bnew = 1'b0; bdrop = 1'b0; bwa = b_hidx;
        awr = 1'b0; anew = 1'b0; adrop = 1'b0; awa = a_hidx;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_start = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN1;
                end
            end
            S_SCAN1, S_SCAN2:
            begin
                scan_rd  = (cnt_reg < CW'(LEVELS));
                scan_acc = (cnt_reg != '0);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(LEVELS))
                begin
                    cnt_next   = '0;
                    state_next = (state_reg == S_SCAN1) ? S_APPLY : S_OUT;
                end
            end
            S_APPLY:
            begin
                scan_start  = 1'b1;
                state_next  = S_SCAN2;
                status_next = ST_DONE;
                case (op_reg) inside
                    OP_SET_BID, OP_LOAD_BID:
                    begin
                        if (op_reg == OP_SET_BID && a_any && price_reg >= a_best)
                        begin
                            status_next = ST_CROSS;
                        end
                        else if (b_hit)
                        begin
                            bwr = 1'b1;
                        end
                        else if (b_free)
                        begin
                            bwr = 1'b1; bnew = 1'b1; bwa = b_fidx;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    OP_SET_ASK, OP_LOAD_ASK:
                    begin
                        if (op_reg == OP_SET_ASK && b_any && price_reg <= b_best)
                        begin
                            status_next = ST_CROSS;
                        end
                        else if (a_hit)
                        begin
                            awr = 1'b1;
                        end
                        else if (a_free)
                        begin
                            awr = 1'b1; anew = 1'b1; awa = a_fidx;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    OP_REMOVE_BID:
                    begin
                        if (b_hit) bdrop = 1'b1;
                        else status_next = ST_ABSENT;
                    end
                    OP_REMOVE_ASK:
                    begin
                        if (a_hit) adrop = 1'b1;
                        else status_next = ST_ABSENT;
                    end
                    OP_CLEAR: clear_all = 1'b1;
                    default: ;
                endcase
            end
            S_OUT:
            begin
                if (out_valid_reg && !out_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign bb32            = 32'(b_best);
    assign ba32            = 32'(a_best);
    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign best_bid        = bb32;
    assign best_ask        = ba32;
    assign spread          = signed'({1'b0, ba32} - {1'b0, bb32});
    assign mid_doubled     = {1'b0, bb32} + {1'b0, ba32};
    assign bid_size_at     = 32'(b_sz);
    assign ask_size_at     = 32'(a_sz);
    assign bid_depth_above = b_dep;
    assign ask_depth_below = a_dep;

    `PLB_ASSERT_IMPL(a_stall_busy, clk, rst_n, out_valid |-> in_stall)
    `PLB_ASSERT_NEXT(a_accept_scan, clk, rst_n, accept, state_reg == S_SCAN1)
    `PLB_ASSERT_IMPL(a_cnt_range, clk, rst_n, cnt_reg <= CW'(LEVELS))
    `PLB_ASSERT_IMPL(a_one_write, clk, rst_n, !(bwr && awr))

endmodule
